// ===== src/hufd_pkg.sv =====
// Shared types and codes of the Huffman decode tree block.
// Input and result payload structs, action, status and sequencer state enums.
// No dependencies.
package hufd_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DECODE = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_DECODED   = 3'd0,
    ST_CLEARED   = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_LEN   = 3'd4,
    ST_DEC_ERR   = 3'd5,
    ST_NOT_READY = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_EV,
    S_INS_LINK,
    S_DEC_EV,
    S_DEC_LEAF
  } state_e;

  typedef struct packed {
    action_e     action;
    logic [15:0] code_bits;
    logic [4:0]  code_length;
    logic [15:0] symbol;
    logic        stream_bit;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] decoded_symbol;
    logic [4:0]  bits_consumed;
  } out_t;

  localparam logic [4:0] DepthSat = 5'd31;

endpackage

// ===== src/hufd_node_mem.sv =====
// Node table memory: one write port and one read port, registered read data.
// No dependencies.
module hufd_node_mem #(
  parameter int Depth = 511,
  parameter int Width = 35
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/huffman_tree_build_and_decode.sv =====
// Huffman decode tree: builds the tree in a node table, then decodes bit by bit.
// Depends on hufd_pkg and hufd_node_mem.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------
//   input    | start, busy (transfer when | in_i  (in_t)
//            | start high and busy low)   |
//   result   | out_strobe_o, one cycle    | out_o (out_t)
//
// Clear and rejected items give their result, registered, in the next cycle;
// unused actions give no result. A decode bit makes two node table reads,
// one when the child is missing. An insert reads one node per code bit and
// links a new node for each missing child, ending with a full status when
// the table runs out. Reset leaves the table unwritten and the tree not ready.
// The receiver cannot stall the block.
module huffman_tree_build_and_decode #(
  parameter int MAX_SYMBOLS  = 256,
  parameter int MAX_CODE_LEN = 16,
  parameter int SYMBOL_BITS  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  hufd_pkg::in_t in_i,
  output logic          out_strobe_o,
  output hufd_pkg::out_t out_o
);

  localparam int TableDepth = 2 * MAX_SYMBOLS - 1;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int NfW        = $clog2(TableDepth + 1);
  localparam int SymW       = (SYMBOL_BITS < 16) ? SYMBOL_BITS : 16;
  localparam int EntW       = 2 * IdxW + SymW + 1;
  localparam logic [NfW-1:0] TableDepthN = NfW'(TableDepth);
  localparam logic [5:0]     MaxLen      = 6'(MAX_CODE_LEN);

  hufd_pkg::state_e state_q, state_d;
  logic [IdxW-1:0]  cur_q, cur_d;
  logic [4:0]       j_q, j_d;
  logic [4:0]       len_q, len_d;
  logic [15:0]      code_q, code_d;
  logic [SymW-1:0]  sym_q, sym_d;
  logic             sbit_q, sbit_d;
  logic [NfW-1:0]   nfn_q, nfn_d;
  logic [IdxW-1:0]  walk_q, walk_d;
  logic [4:0]       wdepth_q, wdepth_d;
  logic             ready_q, ready_d;
  hufd_pkg::out_t   out_q, out_d;
  logic             strobe_q, strobe_d;

  logic             mem_we, mem_re;
  logic [IdxW-1:0]  mem_waddr, mem_raddr;
  logic [EntW-1:0]  mem_wdata, mem_rdata;

  logic [IdxW-1:0]  rd_left, rd_right, ins_child, dec_child, nfn_idx;
  logic [SymW-1:0]  rd_sym;
  logic             rd_leaf, ins_bit;
  logic [4:0]       used;

  hufd_node_mem #(
    .Depth(TableDepth),
    .Width(EntW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_left   = mem_rdata[EntW-1 -: IdxW];
  assign rd_right  = mem_rdata[EntW-1-IdxW -: IdxW];
  assign rd_sym    = mem_rdata[SymW:1];
  assign rd_leaf   = mem_rdata[0];
  assign ins_bit   = (j_q < 5'd16) ? code_q[j_q[3:0]] : 1'b0;
  assign ins_child = ins_bit ? rd_right : rd_left;
  assign dec_child = sbit_q ? rd_right : rd_left;
  assign nfn_idx   = nfn_q[IdxW-1:0];
  assign used      = (wdepth_q < hufd_pkg::DepthSat) ? wdepth_q + 5'd1 : hufd_pkg::DepthSat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hufd_pkg::S_IDLE;
      nfn_q    <= NfW'(1);
      walk_q   <= '0;
      wdepth_q <= '0;
      ready_q  <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      nfn_q    <= nfn_d;
      walk_q   <= walk_d;
      wdepth_q <= wdepth_d;
      ready_q  <= ready_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    j_q    <= j_d;
    len_q  <= len_d;
    code_q <= code_d;
    sym_q  <= sym_d;
    sbit_q <= sbit_d;
    out_q  <= out_d;
  end

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    j_d       = j_q;
    len_d     = len_q;
    code_d    = code_q;
    sym_d     = sym_q;
    sbit_d    = sbit_q;
    nfn_d     = nfn_q;
    walk_d    = walk_q;
    wdepth_d  = wdepth_q;
    ready_d   = ready_q;
    out_d     = '0;
    strobe_d  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state_q)
      hufd_pkg::S_IDLE: begin
        if (start) begin
          len_d  = in_i.code_length;
          code_d = in_i.code_bits;
          sym_d  = in_i.symbol[SymW-1:0];
          sbit_d = in_i.stream_bit;
          unique case (in_i.action)
            hufd_pkg::ACT_CLEAR: begin
              mem_we     = 1'b1;
              nfn_d      = NfW'(1);
              walk_d     = '0;
              wdepth_d   = '0;
              ready_d    = 1'b1;
              strobe_d   = 1'b1;
              out_d.status = hufd_pkg::ST_CLEARED;
            end
            hufd_pkg::ACT_INSERT: begin
              if (!ready_q) begin
                strobe_d     = 1'b1;
                out_d.status = hufd_pkg::ST_NOT_READY;
              end else if (in_i.code_length == 5'd0 ||
                           {1'b0, in_i.code_length} > MaxLen) begin
                strobe_d     = 1'b1;
                out_d.status = hufd_pkg::ST_BAD_LEN;
              end else begin
                mem_re  = 1'b1;
                cur_d   = '0;
                j_d     = '0;
                state_d = hufd_pkg::S_INS_EV;
              end
            end
            hufd_pkg::ACT_DECODE: begin
              if (!ready_q) begin
                strobe_d     = 1'b1;
                out_d.status = hufd_pkg::ST_NOT_READY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = walk_q;
                state_d   = hufd_pkg::S_DEC_EV;
              end
            end
            default: ;
          endcase
        end
      end
      hufd_pkg::S_INS_EV: begin
        if (j_q == len_q) begin
          mem_we       = 1'b1;
          mem_waddr    = cur_q;
          mem_wdata    = {rd_left, rd_right, sym_q, 1'b1};
          strobe_d     = 1'b1;
          out_d.status = hufd_pkg::ST_INSERTED;
          state_d      = hufd_pkg::S_IDLE;
        end else if (ins_child != '0) begin
          mem_re    = 1'b1;
          mem_raddr = ins_child;
          cur_d     = ins_child;
          j_d       = j_q + 5'd1;
        end else if (nfn_q >= TableDepthN) begin
          strobe_d     = 1'b1;
          out_d.status = hufd_pkg::ST_FULL;
          state_d      = hufd_pkg::S_IDLE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = nfn_idx;
          state_d   = hufd_pkg::S_INS_LINK;
        end
      end
      hufd_pkg::S_INS_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = cur_q;
        mem_wdata = ins_bit ? {rd_left, nfn_idx, rd_sym, rd_leaf}
                            : {nfn_idx, rd_right, rd_sym, rd_leaf};
        mem_re    = 1'b1;
        mem_raddr = nfn_idx;
        cur_d     = nfn_idx;
        nfn_d     = nfn_q + NfW'(1);
        j_d       = j_q + 5'd1;
        state_d   = hufd_pkg::S_INS_EV;
      end
      hufd_pkg::S_DEC_EV: begin
        if (dec_child == '0 || NfW'(dec_child) >= TableDepthN) begin
          strobe_d            = 1'b1;
          out_d.status        = hufd_pkg::ST_DEC_ERR;
          out_d.bits_consumed = used;
          walk_d              = '0;
          wdepth_d            = '0;
          state_d             = hufd_pkg::S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = dec_child;
          cur_d     = dec_child;
          state_d   = hufd_pkg::S_DEC_LEAF;
        end
      end
      hufd_pkg::S_DEC_LEAF: begin
        if (rd_leaf) begin
          strobe_d             = 1'b1;
          out_d.status         = hufd_pkg::ST_DECODED;
          out_d.decoded_symbol = 16'(rd_sym);
          out_d.bits_consumed  = used;
          walk_d               = '0;
          wdepth_d             = '0;
        end else begin
          walk_d   = cur_q;
          wdepth_d = used;
        end
        state_d = hufd_pkg::S_IDLE;
      end
      default: state_d = hufd_pkg::S_IDLE;
    endcase
  end

  assign busy         = (state_q != hufd_pkg::S_IDLE);
  assign out_strobe_o = strobe_q;
  assign out_o        = out_q;

endmodule

// ===== src/hufd_checker.sv =====
// Port-level checks of the Huffman decode tree block, bound to the top level.
// Depends on hufd_pkg.
module hufd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input hufd_pkg::in_t  in_i,
  input logic           out_strobe_o,
  input hufd_pkg::out_t out_o
);

  logic xfer;
  assign xfer = start && !busy;

  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && in_i.action == hufd_pkg::ACT_CLEAR |=>
      out_strobe_o && out_o.status == hufd_pkg::ST_CLEARED && !busy)
    else $error("clear transfer without cleared result");

  a_unused_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && in_i.action == hufd_pkg::ACT_NONE |=> !out_strobe_o && !busy)
    else $error("unused action produced a result");

  a_decoded_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && (out_o.status == hufd_pkg::ST_DECODED ||
                     out_o.status == hufd_pkg::ST_DEC_ERR) |->
      out_o.bits_consumed != 5'd0)
    else $error("decode result with zero bits consumed");

  a_symbol_only_decoded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && out_o.status != hufd_pkg::ST_DECODED |->
      out_o.decoded_symbol == 16'd0)
    else $error("symbol shown on a non-decode result");

endmodule

bind huffman_tree_build_and_decode hufd_checker u_hufd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .in_i         (in_i),
  .out_strobe_o (out_strobe_o),
  .out_o        (out_o)
);

// ===== test/huffman_tree_build_and_decode_tb.sv =====
// Testbench for huffman_tree_build_and_decode: builds random prefix code trees,
// decodes bit streams through them and checks every result against a tree model or a directed expectation.
// Depends on hufd_pkg and the block's RTL.
module huffman_tree_build_and_decode_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxSymbols = 256;
  localparam int MaxCodeLen = 16;
  localparam int TableDepth = 2 * MaxSymbols - 1;
  localparam int RandomItems = 1900;
  localparam int DrainCycles = 40;

  typedef struct {
    hufd_pkg::in_t  item;
    bit             typed;
    hufd_pkg::out_t want;
  } step_row_t;

  logic           clk_i;
  logic           rst_ni = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  hufd_pkg::in_t  in_i = '0;
  logic           out_strobe_o;
  hufd_pkg::out_t out_o;

  logic [8:0]  node_left  [TableDepth];
  logic [8:0]  node_right [TableDepth];
  logic [15:0] node_sym   [TableDepth];
  bit          node_leaf  [TableDepth];
  logic [9:0]  free_ptr = 10'd1;
  logic [8:0]  walk_at = '0;
  logic [4:0]  walk_len = '0;
  bit          armed = 1'b0;

  hufd_pkg::out_t due_results[$];
  step_row_t      directed_steps[$];
  int             mismatches = 0;
  int             transfers = 0;
  bit             no_gaps = 1'b0;

  huffman_tree_build_and_decode dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .out_strobe_o(out_strobe_o),
    .out_o       (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Tree model: advance the state by one transfer, return 1 when it yields a result.
  function automatic bit tree_step(input hufd_pkg::in_t it, output hufd_pkg::out_t res);
    logic [8:0] cur;
    logic [8:0] child;
    logic [4:0] used;
    int j;
    res = '0;
    case (it.action)
      hufd_pkg::ACT_CLEAR: begin
        node_left[0]  = '0;
        node_right[0] = '0;
        node_sym[0]   = '0;
        node_leaf[0]  = 1'b0;
        free_ptr   = 10'd1;
        walk_at    = '0;
        walk_len   = '0;
        armed      = 1'b1;
        res.status = hufd_pkg::ST_CLEARED;
        return 1'b1;
      end
      hufd_pkg::ACT_INSERT: begin
        if (!armed) begin
          res.status = hufd_pkg::ST_NOT_READY;
        end else if (it.code_length == 0 || it.code_length > MaxCodeLen) begin
          res.status = hufd_pkg::ST_BAD_LEN;
        end else begin
          res.status = hufd_pkg::ST_INSERTED;
          cur = '0;
          j = 0;
          while (j < it.code_length && res.status == hufd_pkg::ST_INSERTED) begin
            child = it.code_bits[j] ? node_right[cur] : node_left[cur];
            if (child == 0) begin
              if (free_ptr >= TableDepth) begin
                res.status = hufd_pkg::ST_FULL;
              end else begin
                child = free_ptr[8:0];
                free_ptr++;
                node_left[child]  = '0;
                node_right[child] = '0;
                node_sym[child]   = '0;
                node_leaf[child]  = 1'b0;
                if (it.code_bits[j]) node_right[cur] = child;
                else node_left[cur] = child;
              end
            end
            cur = child;
            j++;
          end
          if (res.status == hufd_pkg::ST_INSERTED) begin
            node_leaf[cur] = 1'b1;
            node_sym[cur]  = it.symbol;
          end
        end
        return 1'b1;
      end
      hufd_pkg::ACT_DECODE: begin
        if (!armed) begin
          res.status = hufd_pkg::ST_NOT_READY;
          return 1'b1;
        end
        child = it.stream_bit ? node_right[walk_at] : node_left[walk_at];
        used  = (walk_len < hufd_pkg::DepthSat) ? walk_len + 5'd1 : hufd_pkg::DepthSat;
        if (child == 0 || child >= TableDepth) begin
          walk_at  = '0;
          walk_len = '0;
          res.status        = hufd_pkg::ST_DEC_ERR;
          res.bits_consumed = used;
          return 1'b1;
        end
        if (node_leaf[child]) begin
          walk_at  = '0;
          walk_len = '0;
          res.status         = hufd_pkg::ST_DECODED;
          res.decoded_symbol = node_sym[child];
          res.bits_consumed  = used;
          return 1'b1;
        end
        walk_at  = child;
        walk_len = used;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic hufd_pkg::in_t make_item(input hufd_pkg::action_e a,
                                              input logic [15:0] code,
                                              input logic [4:0] len,
                                              input logic [15:0] sym,
                                              input logic b);
    hufd_pkg::in_t it;
    it.action      = a;
    it.code_bits   = code;
    it.code_length = len;
    it.symbol      = sym;
    it.stream_bit  = b;
    return it;
  endfunction

  function automatic hufd_pkg::in_t noise_item();
    return make_item(hufd_pkg::action_e'($urandom_range(0, 3)), 16'($urandom),
                     5'($urandom_range(0, 31)), 16'($urandom), 1'($urandom_range(0, 1)));
  endfunction

  function automatic void add_row(input hufd_pkg::action_e a, input logic [15:0] code,
                                  input logic [4:0] len, input logic [15:0] sym,
                                  input logic b, input bit typed = 1'b0,
                                  input hufd_pkg::status_e st = hufd_pkg::ST_DECODED,
                                  input logic [15:0] dsym = '0,
                                  input logic [4:0] bits = '0);
    step_row_t r;
    r.item  = make_item(a, code, len, sym, b);
    r.typed = typed;
    r.want.status         = st;
    r.want.decoded_symbol = dsym;
    r.want.bits_consumed  = bits;
    directed_steps.push_back(r);
  endfunction

  task automatic send_item(input hufd_pkg::in_t it, input bit typed = 1'b0,
                           input hufd_pkg::out_t want = '0);
    int             gap;
    hufd_pkg::out_t res;
    bit             has;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    has = tree_step(it, res);
    if (typed) begin
      res = want;
      has = 1'b1;
    end
    if (has) due_results.push_back(res);
    if (it.action != hufd_pkg::ACT_NONE) transfers++;
  endtask

  // Clear, insert a random prefix code (sometimes with holes), then decode codewords mixed with noise items.
  task automatic code_phase();
    logic [15:0] leaf_code[$];
    int          leaf_len[$];
    int          nleaves, i, k, j, tries, nsym;
    send_item(make_item(hufd_pkg::ACT_CLEAR, 16'($urandom), 5'($urandom_range(0, 31)),
                        16'($urandom), 1'($urandom)));
    nleaves = ($urandom_range(0, 15) == 0) ? $urandom_range(2, MaxSymbols)
                                           : $urandom_range(2, 12);
    leaf_code.push_back(16'h0000);
    leaf_len.push_back(1);
    leaf_code.push_back(16'h0001);
    leaf_len.push_back(1);
    for (k = 2; k < nleaves; k++) begin
      i = $urandom_range(0, leaf_code.size() - 1);
      tries = 0;
      while (leaf_len[i] >= MaxCodeLen && tries < 16) begin
        i = $urandom_range(0, leaf_code.size() - 1);
        tries++;
      end
      if (leaf_len[i] < MaxCodeLen) begin
        leaf_code.push_back(leaf_code[i] | (16'h0001 << leaf_len[i]));
        leaf_len.push_back(leaf_len[i] + 1);
        leaf_len[i] = leaf_len[i] + 1;
      end
    end
    for (k = 0; k < leaf_code.size(); k++) begin
      if ($urandom_range(0, 9) != 0) begin
        send_item(make_item(hufd_pkg::ACT_INSERT,
                            16'(leaf_code[k] | ($urandom << leaf_len[k])),
                            5'(leaf_len[k]), 16'($urandom), 1'($urandom)));
      end
    end
    nsym = $urandom_range(4, 30);
    for (k = 0; k < nsym; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(noise_item());
      end else begin
        i = $urandom_range(0, leaf_code.size() - 1);
        for (j = 0; j < leaf_len[i]; j++) begin
          send_item(make_item(hufd_pkg::ACT_DECODE, 16'($urandom),
                              5'($urandom_range(0, 31)), 16'($urandom),
                              leaf_code[i][j]));
        end
      end
    end
  endtask

  // Drive the free pointer to the end of the table with long random codes, then decode random bits.
  task automatic fill_phase();
    int k;
    send_item(make_item(hufd_pkg::ACT_CLEAR, '0, '0, '0, 1'b0));
    repeat (45) begin
      send_item(make_item(hufd_pkg::ACT_INSERT, 16'($urandom),
                          5'($urandom_range(12, MaxCodeLen)), 16'($urandom),
                          1'($urandom)));
    end
    for (k = 0; k < 30; k++) begin
      send_item(make_item(hufd_pkg::ACT_DECODE, 16'($urandom), 5'($urandom_range(0, 31)),
                          16'($urandom), 1'($urandom_range(0, 1))));
    end
  endtask

  always @(posedge clk_i) begin
    hufd_pkg::out_t exp_res;
    if (rst_ni && out_strobe_o) begin
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d symbol %h bits %0d",
                                  out_o.status, out_o.decoded_symbol, out_o.bits_consumed));
      end else begin
        exp_res = due_results.pop_front();
        if (out_o.status !== exp_res.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_o.status,
                                    exp_res.status));
        if (out_o.decoded_symbol !== exp_res.decoded_symbol)
          report_mismatch($sformatf("decoded_symbol %h, expected %h",
                                    out_o.decoded_symbol, exp_res.decoded_symbol));
        if (out_o.bits_consumed !== exp_res.bits_consumed)
          report_mismatch($sformatf("bits_consumed %0d, expected %0d",
                                    out_o.bits_consumed, exp_res.bits_consumed));
      end
    end
  end

  initial begin
    int target;
    int kind;
    add_row(hufd_pkg::ACT_DECODE, 16'hffff, 5'd16, 16'hffff, 1'b1, 1'b1,
            hufd_pkg::ST_NOT_READY);
    add_row(hufd_pkg::ACT_INSERT, 16'h0001, 5'd1, 16'h1111, 1'b0, 1'b1,
            hufd_pkg::ST_NOT_READY);
    add_row(hufd_pkg::ACT_NONE, 16'h0000, 5'd0, 16'h0000, 1'b0);
    add_row(hufd_pkg::ACT_CLEAR, 16'h0000, 5'd0, 16'h0000, 1'b0, 1'b1,
            hufd_pkg::ST_CLEARED);
    add_row(hufd_pkg::ACT_INSERT, 16'h0000, 5'd0, 16'h0001, 1'b0, 1'b1,
            hufd_pkg::ST_BAD_LEN);
    add_row(hufd_pkg::ACT_INSERT, 16'h0001, 5'd17, 16'h0001, 1'b0, 1'b1,
            hufd_pkg::ST_BAD_LEN);
    add_row(hufd_pkg::ACT_INSERT, 16'hffff, 5'd31, 16'hffff, 1'b1, 1'b1,
            hufd_pkg::ST_BAD_LEN);
    add_row(hufd_pkg::ACT_DECODE, 16'h0000, 5'd0, 16'h0000, 1'b0, 1'b1,
            hufd_pkg::ST_DEC_ERR, '0, 5'd1);
    add_row(hufd_pkg::ACT_INSERT, 16'h0000, 5'd1, 16'hffff, 1'b0, 1'b1,
            hufd_pkg::ST_INSERTED);
    add_row(hufd_pkg::ACT_INSERT, 16'h0001, 5'd16, 16'h0000, 1'b0, 1'b1,
            hufd_pkg::ST_INSERTED);
    add_row(hufd_pkg::ACT_INSERT, 16'hffff, 5'd16, 16'h1234, 1'b1, 1'b1,
            hufd_pkg::ST_INSERTED);
    add_row(hufd_pkg::ACT_DECODE, 16'h0000, 5'd0, 16'h0000, 1'b0);
    add_row(hufd_pkg::ACT_DECODE, 16'h0000, 5'd0, 16'h0000, 1'b1);
    add_row(hufd_pkg::ACT_INSERT, 16'h0002, 5'd2, 16'h00aa, 1'b0, 1'b1,
            hufd_pkg::ST_INSERTED);
    add_row(hufd_pkg::ACT_DECODE, 16'h0000, 5'd0, 16'h0000, 1'b0);
    add_row(hufd_pkg::ACT_DECODE, 16'h0000, 5'd0, 16'h0000, 1'b1, 1'b1,
            hufd_pkg::ST_DEC_ERR, '0, 5'd3);
    add_row(hufd_pkg::ACT_INSERT, 16'h0001, 5'd1, 16'h5555, 1'b0, 1'b1,
            hufd_pkg::ST_INSERTED);
    add_row(hufd_pkg::ACT_DECODE, 16'h0000, 5'd0, 16'h0000, 1'b1, 1'b1,
            hufd_pkg::ST_DECODED, 16'h5555, 5'd1);
    add_row(hufd_pkg::ACT_DECODE, 16'h0000, 5'd0, 16'h0000, 1'b0, 1'b1,
            hufd_pkg::ST_DECODED, 16'hffff, 5'd1);
    add_row(hufd_pkg::ACT_CLEAR, 16'hffff, 5'd31, 16'hffff, 1'b1, 1'b1,
            hufd_pkg::ST_CLEARED);
    add_row(hufd_pkg::ACT_DECODE, 16'h0000, 5'd0, 16'h0000, 1'b1, 1'b1,
            hufd_pkg::ST_DEC_ERR, '0, 5'd1);
    add_row(hufd_pkg::ACT_INSERT, 16'h0000, 5'd16, 16'h0000, 1'b0, 1'b1,
            hufd_pkg::ST_INSERTED);
    add_row(hufd_pkg::ACT_NONE, 16'hffff, 5'd31, 16'hffff, 1'b1);
    add_row(hufd_pkg::ACT_DECODE, 16'h0000, 5'd0, 16'h0000, 1'b0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_steps[i]) begin
      send_item(directed_steps[i].item, directed_steps[i].typed, directed_steps[i].want);
    end

    target = transfers + RandomItems;
    while (transfers < target) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        code_phase();
      end else if (kind == 7) begin
        fill_phase();
      end else begin
        repeat (20) send_item(noise_item());
      end
    end
    start <= 1'b0;

    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
